@@ src/rv32sc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32sc_pkg
// Shared types and constants of the instruction core: opcodes, reset values,
// controller states and the command/status groups between control and datapath.
// ----------------------------------------------------------------------------
package rv32sc_pkg;

    localparam logic [31:0] RESET_DATA_BASE = 32'd268435456;
    localparam logic [31:0] RESET_SP        = 32'd268440455;
    localparam logic [4:0]  SP_INDEX        = 5'd2;

    localparam logic [6:0] OP_REG    = 7'b0110011;
    localparam logic [6:0] OP_JAL    = 7'b1101111;
    localparam logic [6:0] OP_BRANCH = 7'b1100011;
    localparam logic [6:0] OP_STORE  = 7'b0100011;
    localparam logic [6:0] OP_IMM    = 7'b0010011;
    localparam logic [6:0] OP_LOAD   = 7'b0000011;
    localparam logic [6:0] OP_JALR   = 7'b1100111;
    localparam logic [6:0] OP_AUIPC  = 7'b0010111;
    localparam logic [6:0] OP_LUI    = 7'b0110111;

    localparam logic [6:0] F7_BASE = 7'b0000000;
    localparam logic [6:0] F7_ALT  = 7'b0100000;
    localparam logic [6:0] F7_MULDIV = 7'b0000001;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SRL  = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;
    localparam logic [2:0] F3_DIV  = 3'd4;
    localparam logic [2:0] F3_REM  = 3'd6;
    localparam logic [2:0] F3_BYTE = 3'd0;
    localparam logic [2:0] F3_HALF = 3'd1;
    localparam logic [2:0] F3_WORD = 3'd2;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_EXEC,
        ST_DIV,
        ST_MEM,
        ST_WB
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic clr_step;
        logic latch_ops;
        logic exec;
        logic div_step;
        logic mem_step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        logic clr_done;
        logic need_div;
        logic need_mem;
        logic div_done;
        logic mem_done;
        logic out_busy;
    } status_t;

endpackage

@@ src/rv32sc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32sc channel interfaces
// Instruction request, result request and configuration write channels.
// ----------------------------------------------------------------------------
interface rv32sc_instr_if;
    logic        valid;
    logic        ready;
    logic [31:0] instruction_word;
    modport source (output valid, output instruction_word, input ready);
    modport sink   (input valid, input instruction_word, output ready);
endinterface

interface rv32sc_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] next_pc;
    logic        write_enable;
    logic [4:0]  write_register;
    logic [31:0] write_value;
    logic        access_fault;
    logic        illegal_op;
    modport source (output valid, output next_pc, output write_enable,
                    output write_register, output write_value,
                    output access_fault, output illegal_op, input ready);
    modport sink   (input valid, input next_pc, input write_enable,
                    input write_register, input write_value,
                    input access_fault, input illegal_op, output ready);
endinterface

interface rv32sc_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_base;
    modport source (output valid, output data_base, input ready);
    modport sink   (input valid, input data_base, output ready);
endinterface

@@ src/rv32sc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32sc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rv32sc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/rv32sc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32sc_ctrl
// Sequencer: memory clear, decode, execute, divide/memory loops, writeback.
// ----------------------------------------------------------------------------
module rv32sc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  rv32sc_pkg::status_t st,
    output rv32sc_pkg::cmd_t    cmd
);

    rv32sc_pkg::state_t state_reg;
    rv32sc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rv32sc_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rv32sc_pkg::ST_CLEAR:
            begin
                if (st.clr_done)
                begin
                    state_next = rv32sc_pkg::ST_IDLE;
                end
            end
            rv32sc_pkg::ST_IDLE:
            begin
                if (st.in_valid)
                begin
                    state_next = rv32sc_pkg::ST_DECODE;
                end
            end
            rv32sc_pkg::ST_DECODE:
            begin
                state_next = rv32sc_pkg::ST_EXEC;
            end
            rv32sc_pkg::ST_EXEC:
            begin
                priority if (st.need_div)
                begin
                    state_next = rv32sc_pkg::ST_DIV;
                end
                else if (st.need_mem)
                begin
                    state_next = rv32sc_pkg::ST_MEM;
                end
                else
                begin
                    state_next = rv32sc_pkg::ST_WB;
                end
            end
            rv32sc_pkg::ST_DIV:
            begin
                if (st.div_done)
                begin
                    state_next = rv32sc_pkg::ST_WB;
                end
            end
            rv32sc_pkg::ST_MEM:
            begin
                if (st.mem_done)
                begin
                    state_next = rv32sc_pkg::ST_WB;
                end
            end
            rv32sc_pkg::ST_WB:
            begin
                if (!st.out_busy)
                begin
                    state_next = rv32sc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rv32sc_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            rv32sc_pkg::ST_CLEAR:  cmd.clr_step  = 1'b1;
            rv32sc_pkg::ST_IDLE:   cmd.in_ready  = 1'b1;
            rv32sc_pkg::ST_DECODE: cmd.latch_ops = 1'b1;
            rv32sc_pkg::ST_EXEC:   cmd.exec      = 1'b1;
            rv32sc_pkg::ST_DIV:    cmd.div_step  = 1'b1;
            rv32sc_pkg::ST_MEM:    cmd.mem_step  = 1'b1;
            rv32sc_pkg::ST_WB:     cmd.commit    = !st.out_busy;
            default:               cmd = '0;
        endcase
    end

endmodule

@@ src/rv32sc_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32sc_dp
// Datapath: register file, ALU, multiplier, serial divider, byte data memory,
// program counter and result register.
// ----------------------------------------------------------------------------
module rv32sc_dp #(
    parameter int DATA_BYTES = 8192
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rv32sc_pkg::cmd_t    cmd,
    output rv32sc_pkg::status_t st,
    input  logic                in_valid,
    input  logic [31:0]         in_word,
    input  logic                cfg_valid,
    input  logic [31:0]         cfg_data,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [31:0]         out_next_pc,
    output logic                out_write_enable,
    output logic [4:0]          out_write_register,
    output logic [31:0]         out_write_value,
    output logic                out_access_fault,
    output logic                out_illegal_op
);

    localparam int          AW = $clog2(DATA_BYTES);
    localparam logic [31:0] DB = 32'(DATA_BYTES);

    // configuration and architectural state
    logic [31:0] base_reg;
    logic [31:0] pc_reg;
    logic [31:0] rf_valid_reg;

    // item state
    logic [31:0] instr_reg;
    logic [31:0] a_reg;
    logic [31:0] b_reg;
    logic [31:0] res_reg;
    logic [31:0] npc_reg;
    logic        wr_reg;
    logic        fault_reg;
    logic        ill_reg;
    logic        is_load_reg;
    logic        is_store_reg;
    logic        is_div_reg;
    logic [AW-1:0] off_reg;
    logic [2:0]  size_reg;
    logic [2:0]  mcnt_reg;
    logic [31:0] ld_reg;
    logic [31:0] quo_reg;
    logic [31:0] rem_reg;
    logic [31:0] ub_reg;
    logic [4:0]  dcnt_reg;
    logic [AW-1:0] clr_reg;

    // result register
    logic        out_valid_reg;
    logic [31:0] out_npc_reg;
    logic        out_we_reg;
    logic [4:0]  out_rd_reg;
    logic [31:0] out_val_reg;
    logic        out_fault_reg;
    logic        out_ill_reg;

    logic [31:0] rf_rdata_a;
    logic [31:0] rf_rdata_b;
    logic [7:0]  dm_rdata;
    logic        dm_we;
    logic [AW-1:0] dm_addr;
    logic [7:0]  dm_wdata;

    logic [6:0]  op;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [4:0]  rd;
    logic [31:0] immi;
    logic [31:0] imms;
    logic [31:0] immb;
    logic [31:0] immj;
    logic [31:0] ex_val;
    logic [31:0] ex_npc;
    logic        ex_wr;
    logic        ex_ill;
    logic        ex_fault;
    logic        ex_load;
    logic        ex_store;
    logic        ex_div;
    logic [31:0] ex_addr;
    logic [31:0] ex_off;
    logic [2:0]  ex_size;
    logic [31:0] mul_res;
    logic [32:0] trial;
    logic [31:0] wb_val;
    logic [31:0] q_signed;
    logic [31:0] r_signed;
    logic        commit_wr;
    logic        accept;

    assign accept = in_valid && cmd.in_ready;
    assign op = instr_reg[6:0];
    assign f3 = instr_reg[14:12];
    assign f7 = instr_reg[31:25];
    assign rd = instr_reg[11:7];
    assign immi = {{20{instr_reg[31]}}, instr_reg[31:20]};
    assign imms = {{20{instr_reg[31]}}, instr_reg[31:25], instr_reg[11:7]};
    assign immb = {{20{instr_reg[31]}}, instr_reg[7], instr_reg[30:25],
                   instr_reg[11:8], 1'b0};
    assign immj = {{12{instr_reg[31]}}, instr_reg[19:12], instr_reg[20],
                   instr_reg[30:21], 1'b0};
    assign mul_res = a_reg * b_reg;

    // two register file copies give two read ports
    rv32sc_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
        .clk   (clk),
        .we    (commit_wr),
        .waddr (rd),
        .wdata (wb_val),
        .raddr (in_word[19:15]),
        .rdata (rf_rdata_a)
    );

    rv32sc_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
        .clk   (clk),
        .we    (commit_wr),
        .waddr (rd),
        .wdata (wb_val),
        .raddr (in_word[24:20]),
        .rdata (rf_rdata_b)
    );

    rv32sc_ram #(.WIDTH(8), .DEPTH(DATA_BYTES)) u_dmem (
        .clk   (clk),
        .we    (dm_we),
        .waddr (dm_addr),
        .wdata (dm_wdata),
        .raddr (dm_addr),
        .rdata (dm_rdata)
    );

    always_comb
    begin
        dm_we = cmd.clr_step || (cmd.mem_step && is_store_reg);
        dm_addr = cmd.clr_step ? clr_reg : off_reg + AW'(mcnt_reg);
        dm_wdata = 8'd0;
        if (!cmd.clr_step)
        begin
            unique case (mcnt_reg[1:0])
                2'd0: dm_wdata = b_reg[7:0];
                2'd1: dm_wdata = b_reg[15:8];
                2'd2: dm_wdata = b_reg[23:16];
                2'd3: dm_wdata = b_reg[31:24];
                default: dm_wdata = 8'd0;
            endcase
        end
    end

    // execute decode
    always_comb
    begin
        ex_val = 32'd0;
        ex_npc = pc_reg + 32'd4;
        ex_wr = 1'b0;
        ex_ill = 1'b0;
        ex_fault = 1'b0;
        ex_load = 1'b0;
        ex_store = 1'b0;
        ex_div = 1'b0;
        ex_addr = a_reg + ((op == rv32sc_pkg::OP_STORE) ? imms : immi);
        ex_off = ex_addr - base_reg;
        ex_size = (f3 == rv32sc_pkg::F3_BYTE) ? 3'd1 :
                  (f3 == rv32sc_pkg::F3_HALF) ? 3'd2 : 3'd4;
        unique case (op)
            rv32sc_pkg::OP_REG:
            begin
                ex_wr = 1'b1;
                if (f7 == rv32sc_pkg::F7_BASE)
                begin
                    unique case (f3)
                        rv32sc_pkg::F3_ADD: ex_val = a_reg + b_reg;
                        rv32sc_pkg::F3_SLL: ex_val = a_reg << b_reg[4:0];
                        rv32sc_pkg::F3_SLT: ex_val = {31'd0, $signed(a_reg) < $signed(b_reg)};
                        rv32sc_pkg::F3_XOR: ex_val = a_reg ^ b_reg;
                        rv32sc_pkg::F3_SRL: ex_val = a_reg >> b_reg[4:0];
                        rv32sc_pkg::F3_OR:  ex_val = a_reg | b_reg;
                        rv32sc_pkg::F3_AND: ex_val = a_reg & b_reg;
                        default:            ex_ill = 1'b1;
                    endcase
                end
                else if (f7 == rv32sc_pkg::F7_ALT && f3 == rv32sc_pkg::F3_ADD)
                begin
                    ex_val = a_reg - b_reg;
                end
                else if (f7 == rv32sc_pkg::F7_ALT && f3 == rv32sc_pkg::F3_SRL)
                begin
                    ex_val = 32'($signed(a_reg) >>> b_reg[4:0]);
                end
                else if (f7 == rv32sc_pkg::F7_MULDIV && f3 == rv32sc_pkg::F3_ADD)
                begin
                    ex_val = mul_res;
                end
                else if (f7 == rv32sc_pkg::F7_MULDIV &&
                         (f3 == rv32sc_pkg::F3_DIV || f3 == rv32sc_pkg::F3_REM))
                begin
                    ex_div = 1'b1;
                end
                else
                begin
                    ex_ill = 1'b1;
                end
            end
            rv32sc_pkg::OP_IMM:
            begin
                ex_wr = 1'b1;
                priority if (f3 == rv32sc_pkg::F3_ADD) ex_val = a_reg + immi;
                else if (f3 == rv32sc_pkg::F3_AND)     ex_val = a_reg & immi;
                else if (f3 == rv32sc_pkg::F3_OR)      ex_val = a_reg | immi;
                else                                   ex_ill = 1'b1;
            end
            rv32sc_pkg::OP_LOAD, rv32sc_pkg::OP_STORE:
            begin
                if (f3 > rv32sc_pkg::F3_WORD)
                begin
                    ex_ill = 1'b1;
                end
                else if (ex_off > DB - 32'(ex_size))
                begin
                    ex_fault = 1'b1;
                end
                else
                begin
                    ex_load = (op == rv32sc_pkg::OP_LOAD);
                    ex_store = (op == rv32sc_pkg::OP_STORE);
                    ex_wr = ex_load;
                end
            end
            rv32sc_pkg::OP_BRANCH:
            begin
                unique case (f3)
                    rv32sc_pkg::F3_BEQ: if (a_reg == b_reg) ex_npc = pc_reg + immb;
                    rv32sc_pkg::F3_BNE: if (a_reg != b_reg) ex_npc = pc_reg + immb;
                    rv32sc_pkg::F3_BLT:
                        if ($signed(a_reg) < $signed(b_reg)) ex_npc = pc_reg + immb;
                    rv32sc_pkg::F3_BGE:
                        if ($signed(a_reg) >= $signed(b_reg)) ex_npc = pc_reg + immb;
                    default: ex_ill = 1'b1;
                endcase
            end
            rv32sc_pkg::OP_JAL:
            begin
                ex_wr = 1'b1;
                ex_val = pc_reg + 32'd4;
                ex_npc = pc_reg + immj;
            end
            rv32sc_pkg::OP_JALR:
            begin
                if (f3 != rv32sc_pkg::F3_ADD)
                begin
                    ex_ill = 1'b1;
                end
                else
                begin
                    ex_wr = 1'b1;
                    ex_val = pc_reg + 32'd4;
                    ex_npc = (a_reg + immi) & ~32'd1;
                end
            end
            rv32sc_pkg::OP_LUI:
            begin
                ex_wr = 1'b1;
                ex_val = {instr_reg[31:12], 12'd0};
            end
            rv32sc_pkg::OP_AUIPC:
            begin
                ex_wr = 1'b1;
                ex_val = pc_reg + {instr_reg[31:12], 12'd0};
            end
            default:
            begin
                ex_ill = 1'b1;
            end
        endcase
        if (ex_ill)
        begin
            ex_wr = 1'b0;
            ex_npc = pc_reg + 32'd4;
        end
        if (ex_fault)
        begin
            ex_wr = 1'b0;
            ex_npc = pc_reg;
        end
        if (rd == 5'd0)
        begin
            ex_wr = 1'b0;
        end
    end

    // restoring divide step on magnitudes
    assign trial = {rem_reg, quo_reg[31]} - {1'b0, ub_reg};
    assign q_signed = (a_reg[31] != b_reg[31]) ? 32'd0 - quo_reg : quo_reg;
    assign r_signed = a_reg[31] ? 32'd0 - rem_reg : rem_reg;

    always_comb
    begin
        wb_val = res_reg;
        if (is_load_reg)
        begin
            priority if (f3 == rv32sc_pkg::F3_BYTE) wb_val = {{24{ld_reg[7]}}, ld_reg[7:0]};
            else if (f3 == rv32sc_pkg::F3_HALF)     wb_val = {{16{ld_reg[15]}}, ld_reg[15:0]};
            else                                    wb_val = ld_reg;
        end
        else if (is_div_reg)
        begin
            if (b_reg == 32'd0)
            begin
                wb_val = (f3 == rv32sc_pkg::F3_DIV) ? 32'hFFFF_FFFF : a_reg;
            end
            else
            begin
                wb_val = (f3 == rv32sc_pkg::F3_DIV) ? q_signed : r_signed;
            end
        end
    end

    assign commit_wr = cmd.commit && wr_reg;

    always_comb
    begin
        st.in_valid = in_valid;
        st.clr_done = (clr_reg == AW'(DATA_BYTES - 1));
        st.need_div = ex_div && !ex_ill;
        st.need_mem = ex_load || ex_store;
        st.div_done = (dcnt_reg == 5'd31);
        st.mem_done = is_store_reg ? (mcnt_reg == size_reg - 3'd1) : (mcnt_reg == size_reg);
        st.out_busy = out_valid_reg && !out_ready;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= rv32sc_pkg::RESET_DATA_BASE;
            pc_reg <= 32'd0;
            rf_valid_reg <= 32'd0;
            clr_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                base_reg <= cfg_data;
            end
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.commit)
            begin
                pc_reg <= npc_reg;
                out_valid_reg <= 1'b1;
                if (wr_reg)
                begin
                    rf_valid_reg[rd] <= 1'b1;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            instr_reg <= in_word;
        end
        if (cmd.latch_ops)
        begin
            // entries never written read as their reset value
            a_reg <= rf_valid_reg[instr_reg[19:15]] ? rf_rdata_a :
                     (instr_reg[19:15] == rv32sc_pkg::SP_INDEX) ? rv32sc_pkg::RESET_SP : 32'd0;
            b_reg <= rf_valid_reg[instr_reg[24:20]] ? rf_rdata_b :
                     (instr_reg[24:20] == rv32sc_pkg::SP_INDEX) ? rv32sc_pkg::RESET_SP : 32'd0;
        end
        if (cmd.exec)
        begin
            res_reg <= ex_val;
            npc_reg <= ex_npc;
            wr_reg <= ex_wr;
            fault_reg <= ex_fault;
            ill_reg <= ex_ill;
            is_load_reg <= ex_load;
            is_store_reg <= ex_store;
            is_div_reg <= ex_div && !ex_ill;
            off_reg <= ex_off[AW-1:0];
            size_reg <= ex_size;
            mcnt_reg <= 3'd0;
            ld_reg <= 32'd0;
            quo_reg <= a_reg[31] ? 32'd0 - a_reg : a_reg;
            ub_reg <= b_reg[31] ? 32'd0 - b_reg : b_reg;
            rem_reg <= 32'd0;
            dcnt_reg <= 5'd0;
        end
        if (cmd.div_step)
        begin
            dcnt_reg <= dcnt_reg + 5'd1;
            if (!trial[32])
            begin
                rem_reg <= trial[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[30:0], quo_reg[31]};
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
        if (cmd.mem_step)
        begin
            mcnt_reg <= mcnt_reg + 3'd1;
            // read data is registered, so each byte arrives in the cycle after its address
            if (!is_store_reg)
            begin
                unique case (mcnt_reg)
                    3'd1: ld_reg[7:0]   <= dm_rdata;
                    3'd2: ld_reg[15:8]  <= dm_rdata;
                    3'd3: ld_reg[23:16] <= dm_rdata;
                    3'd4: ld_reg[31:24] <= dm_rdata;
                    default: ld_reg <= ld_reg;
                endcase
            end
        end
        if (cmd.commit)
        begin
            out_npc_reg <= npc_reg;
            out_we_reg <= wr_reg;
            out_rd_reg <= wr_reg ? rd : 5'd0;
            out_val_reg <= wr_reg ? wb_val : 32'd0;
            out_fault_reg <= fault_reg;
            out_ill_reg <= ill_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_next_pc = out_npc_reg;
    assign out_write_enable = out_we_reg;
    assign out_write_register = out_rd_reg;
    assign out_write_value = out_val_reg;
    assign out_access_fault = out_fault_reg;
    assign out_illegal_op = out_ill_reg;

endmodule

@@ src/rv32_subset_instruction_core_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32_subset_instruction_core_top
// RV32IM-subset multicycle core executing one instruction per request.
// ----------------------------------------------------------------------------
// Usage:
//   instr  : one request carries the instruction word fetched at the current
//            program counter (the next_pc of the previous result).
//   result : one request per instruction with next PC, register writeback,
//            access fault and illegal-instruction flags.
//   cfg    : writes data_base, the start address of the data window; ready is
//            always high; write only while the core is idle.
// Div/rem results come from the serial divider, one quotient bit per cycle;
// in-window loads and stores move size bytes, size being 1, 2 or 4, through
// the single byte memory port.
// One instruction is in flight at a time; the next is taken once the previous
// result is in the output register, even if the receiver has not taken it.
// A stalled receiver holds the result and blocks writeback of the following
// instruction.
// Reset: PC, registers (x2 = 268440455) and data_base are restored at once;
// the data memory is then cleared at one byte per cycle, all DATA_BYTES bytes,
// and no instruction is accepted until it is done.
// ----------------------------------------------------------------------------
module rv32_subset_instruction_core_top #(
    parameter int DATA_BYTES = 8192
) (
    input logic             clk,
    input logic             rst_n,
    rv32sc_instr_if.sink    instr,
    rv32sc_result_if.source result,
    rv32sc_cfg_if.sink      cfg
);

    rv32sc_pkg::cmd_t    cmd;
    rv32sc_pkg::status_t st;

    assign instr.ready = cmd.in_ready;
    assign cfg.ready = 1'b1;

    rv32sc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    rv32sc_dp #(.DATA_BYTES(DATA_BYTES)) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .st                 (st),
        .in_valid           (instr.valid),
        .in_word            (instr.instruction_word),
        .cfg_valid          (cfg.valid),
        .cfg_data           (cfg.data_base),
        .out_ready          (result.ready),
        .out_valid          (result.valid),
        .out_next_pc        (result.next_pc),
        .out_write_enable   (result.write_enable),
        .out_write_register (result.write_register),
        .out_write_value    (result.write_value),
        .out_access_fault   (result.access_fault),
        .out_illegal_op     (result.illegal_op)
    );

endmodule

@@ src/rv32sc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32sc_checker
// Port-level checks of the instruction core, bound to the top level.
// ----------------------------------------------------------------------------
module rv32sc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] next_pc,
    input logic        write_enable,
    input logic [4:0]  write_register,
    input logic [31:0] write_value,
    input logic        access_fault,
    input logic        illegal_op
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(next_pc) && $stable(write_value))
        else $error("result changed while stalled");

    // no result can follow an accepted request in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result too early");

    // faults and illegal instructions never write
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (access_fault || illegal_op) |-> !write_enable)
        else $error("write on fault or illegal instruction");

    // without a write, index and value are zero; x0 is never written
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !write_enable |-> write_register == 5'd0 && write_value == 32'd0)
        else $error("stale writeback fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && write_enable |-> write_register != 5'd0 && !access_fault)
        else $error("bad writeback index");

endmodule

bind rv32_subset_instruction_core_top rv32sc_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (instr.valid),
    .in_ready       (instr.ready),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .next_pc        (result.next_pc),
    .write_enable   (result.write_enable),
    .write_register (result.write_register),
    .write_value    (result.write_value),
    .access_fault   (result.access_fault),
    .illegal_op     (result.illegal_op)
);
